/* sv/mipmap_box_downsample_unit_assert.svh */
// Assertion macros shared by the mipmap downsample RTL.
// No dependencies; include with the bare file name.
`ifndef MIPMAP_BOX_DOWNSAMPLE_UNIT_ASSERT_SVH
`define MIPMAP_BOX_DOWNSAMPLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbd assertion failed");

// Next-cycle implication, checked out of reset.
`define MBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbd assertion failed");

`endif

/* sv/mbd_pkg.sv */
// Shared constants, types and helpers for the mipmap box downsample unit.
// No dependencies.
package mbd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    localparam int DIM_W  = 13;                   // config register width
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CHAN_W = 8;
    localparam int SUM_W  = CHAN_W + 1;
    localparam int NUM_CHAN = 4;
    localparam int LINE_W = NUM_CHAN * SUM_W;
    localparam int CNT_W  = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = FIFO_AW + 1;

    typedef struct packed {
        logic hold;    // capture pixel as held (even position)
        logic load;    // stage-1 load of pair sum
        logic pass;    // single-pixel image: pass through
        logic mode2d;  // stage-1 item is a 2x2 average
    } t_lane_ctl;

    typedef struct packed {
        logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;
        logic                            last;
    } t_out_item;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

/* sv/mbd_line_buf.sv */
// Line buffer of horizontal pair sums, one entry per output column.
// Depends on mbd_pkg.
module mbd_line_buf (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [mbd_pkg::LINE_AW-1:0]       i_wr_addr,
    input  logic [mbd_pkg::LINE_W-1:0]        i_wr_data,
    input  logic                              i_rd_en,
    input  logic [mbd_pkg::LINE_AW-1:0]       i_rd_addr,
    output logic [mbd_pkg::LINE_W-1:0]        o_rd_data
);

    logic [mbd_pkg::LINE_W-1:0] r_mem [mbd_pkg::LINE_DEPTH];
    logic [mbd_pkg::LINE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/mbd_lane.sv */
// One channel lane: held byte, pair sum, and the final shift average.
// Depends on mbd_pkg.
module mbd_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mbd_pkg::t_lane_ctl            i_ctl,
    input  logic [mbd_pkg::CHAN_W-1:0]    i_px,
    input  logic [mbd_pkg::SUM_W-1:0]     i_line,
    output logic [mbd_pkg::SUM_W-1:0]     o_sum,
    output logic [mbd_pkg::CHAN_W-1:0]    o_res
);

    logic [mbd_pkg::CHAN_W-1:0] r_held;
    logic [mbd_pkg::SUM_W-1:0]  r_sum;
    logic [mbd_pkg::SUM_W-1:0]  n_sum;
    logic [mbd_pkg::SUM_W:0]    sum2d;

    assign o_sum = {1'b0, r_held} + {1'b0, i_px};
    // pass-through is stored doubled so the common >>1 returns it unchanged
    assign n_sum = i_ctl.pass ? {i_px, 1'b0} : o_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_ctl.hold) begin
            r_held <= i_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sum <= n_sum;
        end
    end

    assign sum2d = {1'b0, i_line} + {1'b0, r_sum};
    assign o_res = i_ctl.mode2d ? sum2d[mbd_pkg::SUM_W:2] : r_sum[mbd_pkg::SUM_W-1:1];

endmodule

/* sv/mbd_out_queue.sv */
// Output queue of result records, each holding all lane results and the frame-last flag.
// Depends on mbd_pkg.
module mbd_out_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  mbd_pkg::t_out_item                i_item,
    input  logic                              i_stall,
    output logic                              o_valid,
    output mbd_pkg::t_out_item                o_item,
    output logic [mbd_pkg::FIFO_LVL_W-1:0]    o_level
);

    mbd_pkg::t_out_item                r_mem [mbd_pkg::FIFO_DEPTH];
    logic [mbd_pkg::FIFO_AW-1:0]       r_wr_ptr;
    logic [mbd_pkg::FIFO_AW-1:0]       r_rd_ptr;
    logic [mbd_pkg::FIFO_LVL_W-1:0]    r_level;
    logic                              pop;

    assign o_valid = (r_level != '0);
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_level <= r_level + 1'b1;
            end else if (pop && !i_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_level = r_level;

endmodule

/* sv/mipmap_box_downsample_unit.sv */
// Each result is registered in the stage-1 lane registers, then queued for output.
// Throughput: one pixel per cycle while o_stall is low; four channel lanes and one
// line-buffer read port. o_stall rises only when queued plus in-flight results
// fill the four-entry output queue. Reset (synchronous, active low): width 1,
// height 1, four channels, raster position 0, output queue empty. Line buffer
// contents are not cleared; a width, height or channel-count write restarts the frame.
`include "mipmap_box_downsample_unit_assert.svh"

module mipmap_box_downsample_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [mbd_pkg::CHAN_W-1:0]         i_chan_a,
    input  logic [mbd_pkg::CHAN_W-1:0]         i_chan_b,
    input  logic [mbd_pkg::CHAN_W-1:0]         i_chan_c,
    input  logic [mbd_pkg::CHAN_W-1:0]         i_chan_d,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [mbd_pkg::CHAN_W-1:0]         o_out_a,
    output logic [mbd_pkg::CHAN_W-1:0]         o_out_b,
    output logic [mbd_pkg::CHAN_W-1:0]         o_out_c,
    output logic [mbd_pkg::CHAN_W-1:0]         o_out_d,
    output logic                               o_frame_last
);

    localparam logic [mbd_pkg::DIM_W-1:0] MaxW = mbd_pkg::DIM_W'(mbd_pkg::MAX_WIDTH);
    localparam logic [mbd_pkg::DIM_W-1:0] MaxH = mbd_pkg::DIM_W'(mbd_pkg::MAX_HEIGHT);
    localparam logic [mbd_pkg::DIM_W-1:0] One  = mbd_pkg::DIM_W'(1);

    logic [mbd_pkg::DIM_W-1:0]  r_width;
    logic [mbd_pkg::DIM_W-1:0]  r_height;
    logic [mbd_pkg::CNT_W-1:0]  r_chan_cnt;
    logic [mbd_pkg::COL_W-1:0]  r_col;
    logic [mbd_pkg::ROW_W-1:0]  r_row;
    logic [mbd_pkg::COL_W-1:0]  n_col;
    logic [mbd_pkg::ROW_W-1:0]  n_row;
    logic                       r_s1_vld;
    logic                       r_s1_last;
    logic                       r_s1_2d;

    logic [mbd_pkg::DIM_W-1:0]  we;
    logic [mbd_pkg::DIM_W-1:0]  he;
    logic [mbd_pkg::DIM_W-1:0]  col_x;
    logic [mbd_pkg::DIM_W-1:0]  row_x;
    logic [mbd_pkg::DIM_W-1:0]  len;
    logic [mbd_pkg::DIM_W-1:0]  pos;
    logic [mbd_pkg::DIM_W-1:0]  len_even;
    logic [mbd_pkg::DIM_W-1:0]  we_even;
    logic [mbd_pkg::DIM_W-1:0]  he_even;
    logic                       one_d;
    logic                       pass;
    logic                       in_rows;
    logic                       line_wr;
    logic                       line_rd;
    logic                       produce;
    logic                       last;
    logic                       hold;
    logic                       ch_ok;
    logic                       accept;
    logic                       cfg_wr;
    logic                       s1_load;

    logic [mbd_pkg::NUM_CHAN-1:0][mbd_pkg::CHAN_W-1:0] chan_in;
    logic [mbd_pkg::NUM_CHAN-1:0][mbd_pkg::CHAN_W-1:0] px;
    logic [mbd_pkg::NUM_CHAN-1:0][mbd_pkg::CHAN_W-1:0] lane_res;
    logic [mbd_pkg::LINE_W-1:0]                        line_wdata;
    logic [mbd_pkg::LINE_W-1:0]                        line_rdata;
    logic [mbd_pkg::LINE_AW-1:0]                       line_addr;
    mbd_pkg::t_lane_ctl                                lane_ctl;
    mbd_pkg::t_out_item                                push_item;
    mbd_pkg::t_out_item                                head_item;
    logic [mbd_pkg::FIFO_LVL_W-1:0]                    q_level;
    logic [mbd_pkg::FIFO_LVL_W:0]                      q_commit;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid && o_cfg_ready &&
                    (i_cfg_index == mbd_pkg::CFG_IMAGE_WIDTH ||
                     i_cfg_index == mbd_pkg::CFG_IMAGE_HEIGHT ||
                     i_cfg_index == mbd_pkg::CFG_CHANNEL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= One;
            r_height   <= One;
            r_chan_cnt <= mbd_pkg::CNT_W'(mbd_pkg::NUM_CHAN);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mbd_pkg::CFG_IMAGE_WIDTH:   r_width    <= i_cfg_data;
                mbd_pkg::CFG_IMAGE_HEIGHT:  r_height   <= i_cfg_data;
                mbd_pkg::CFG_CHANNEL_COUNT: r_chan_cnt <= i_cfg_data[mbd_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- position decode ----------------
    assign we       = mbd_pkg::clamp_dim(r_width, MaxW);
    assign he       = mbd_pkg::clamp_dim(r_height, MaxH);
    assign col_x    = mbd_pkg::DIM_W'(r_col);
    assign row_x    = mbd_pkg::DIM_W'(r_row);
    assign one_d    = (we == One) || (he == One);
    assign len      = (we == One) ? he : we;
    assign pos      = (he == One) ? col_x : row_x;
    assign len_even = {len[mbd_pkg::DIM_W-1:1], 1'b0};
    assign we_even  = {we[mbd_pkg::DIM_W-1:1], 1'b0};
    assign he_even  = {he[mbd_pkg::DIM_W-1:1], 1'b0};
    assign pass     = one_d && (len == One);
    assign ch_ok    = (r_chan_cnt != '0) &&
                      (r_chan_cnt <= mbd_pkg::CNT_W'(mbd_pkg::NUM_CHAN));

    // an odd trailing row in 2D mode is dropped
    assign in_rows = row_x < he_even;
    assign line_wr = r_col[0] && in_rows && !r_row[0];
    assign line_rd = r_col[0] && in_rows && r_row[0];

    always_comb begin
        if (one_d) begin
            produce = pass || pos[0];
            last    = pass || (pos == len_even - One);
            hold    = !pass && !pos[0];
        end else begin
            produce = line_rd;
            last    = (row_x == he_even - One) && (col_x == we_even - One);
            hold    = !r_col[0];
        end
    end

    assign accept  = i_valid && !o_stall;
    assign s1_load = accept && produce && ch_ok;

    // ---------------- raster counters ----------------
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_x + One >= we) begin
                n_col = '0;
                if (row_x + One >= he) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= s1_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_last <= last;
            r_s1_2d   <= !one_d;
        end
    end

    // ---------------- lanes ----------------
    assign chan_in = {i_chan_d, i_chan_c, i_chan_b, i_chan_a};

    assign lane_ctl.hold   = accept && hold;
    assign lane_ctl.load   = s1_load;
    assign lane_ctl.pass   = pass;
    assign lane_ctl.mode2d = r_s1_2d;

    for (genvar k = 0; k < mbd_pkg::NUM_CHAN; k++) begin : g_lane
        assign px[k] = (r_chan_cnt > mbd_pkg::CNT_W'(k)) ? chan_in[k] : '0;

        mbd_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_px    (px[k]),
            .i_line  (line_rdata[k*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]),
            .o_sum   (line_wdata[k*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]),
            .o_res   (lane_res[k])
        );
    end

    assign line_addr = r_col[mbd_pkg::LINE_AW:1];

    mbd_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (accept && !one_d && line_wr),
        .i_wr_addr (line_addr),
        .i_wr_data (line_wdata),
        .i_rd_en   (s1_load && !one_d),
        .i_rd_addr (line_addr),
        .o_rd_data (line_rdata)
    );

    // ---------------- merge and output ----------------
    assign push_item.chan = lane_res;
    assign push_item.last = r_s1_last;

    mbd_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_vld),
        .i_item  (push_item),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_item  (head_item),
        .o_level (q_level)
    );

    // queued plus in-flight results must leave room for one more transfer
    assign q_commit = {1'b0, q_level} + {{mbd_pkg::FIFO_LVL_W{1'b0}}, r_s1_vld};
    assign o_stall  = q_commit >= (mbd_pkg::FIFO_LVL_W + 1)'(mbd_pkg::FIFO_DEPTH);

    assign o_out_a      = head_item.chan[0];
    assign o_out_b      = head_item.chan[1];
    assign o_out_c      = head_item.chan[2];
    assign o_out_d      = head_item.chan[3];
    assign o_frame_last = head_item.last;

    // ---------------- assertions ----------------
    `MBD_ASSERT_NOW(a_queue_room, i_clk, i_rst_n, r_s1_vld,
        q_level != mbd_pkg::FIFO_LVL_W'(mbd_pkg::FIFO_DEPTH))
    `MBD_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, cfg_wr, (r_col == '0) && (r_row == '0))
    `MBD_ASSERT_NOW(a_col_range, i_clk, i_rst_n, 1'b1, col_x < we)
    `MBD_ASSERT_NEXT(a_no_result_bad_cnt, i_clk, i_rst_n, accept && !ch_ok, !r_s1_vld)

endmodule

/* dv/testbench.sv */
// Self-checking testbench for mipmap_box_downsample_unit: directed plan, then random frames.
// Compares every output pixel against a built-in 2x2 / pairwise box-filter predictor.
// Depends on mbd_pkg and the mipmap_box_downsample_unit RTL.
module testbench;

    localparam logic [mbd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;   // decoded by nothing
    localparam int SETTLE_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int HOLD_CYCLES       = 80;
    localparam int ITEMS_PER_PHASE   = 440;
    localparam int BURST_ITEMS       = 40;

    typedef enum logic {PLAN_CFG, PLAN_PIX} t_plan_kind;

    typedef struct {
        t_plan_kind                          kind;
        logic [mbd_pkg::CFG_IDX_W-1:0]       idx;
        logic [mbd_pkg::CFG_DATA_W-1:0]      data;
        logic [3:0][7:0]                     pix;
        bit                                  fixed;
        mbd_pkg::t_out_item                  want;
    } t_plan_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [mbd_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [mbd_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic [mbd_pkg::CHAN_W-1:0]          i_chan_a = '0;
    logic [mbd_pkg::CHAN_W-1:0]          i_chan_b = '0;
    logic [mbd_pkg::CHAN_W-1:0]          i_chan_c = '0;
    logic [mbd_pkg::CHAN_W-1:0]          i_chan_d = '0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic [mbd_pkg::CHAN_W-1:0]          o_out_a;
    logic [mbd_pkg::CHAN_W-1:0]          o_out_b;
    logic [mbd_pkg::CHAN_W-1:0]          o_out_c;
    logic [mbd_pkg::CHAN_W-1:0]          o_out_d;
    logic                                o_frame_last;

    mipmap_box_downsample_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_chan_a     (i_chan_a),
        .i_chan_b     (i_chan_b),
        .i_chan_c     (i_chan_c),
        .i_chan_d     (i_chan_d),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_a      (o_out_a),
        .o_out_b      (o_out_b),
        .o_out_c      (o_out_c),
        .o_out_d      (o_out_d),
        .o_frame_last (o_frame_last)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [mbd_pkg::DIM_W-1:0]   img_w = mbd_pkg::DIM_W'(1);
    logic [mbd_pkg::DIM_W-1:0]   img_h = mbd_pkg::DIM_W'(1);
    logic [mbd_pkg::CNT_W-1:0]   chan_cnt = mbd_pkg::CNT_W'(4);
    int                          col_pos = 0;
    int                          row_pos = 0;
    logic [3:0][7:0]             held_px = '0;
    logic [3:0][8:0]             pair_sums [mbd_pkg::LINE_DEPTH];

    mbd_pkg::t_out_item          expected_mip_px [$];
    int                          err_count = 0;
    int                          tx_pct = 36;
    int                          rx_pct = 63;
    int                          hold_asks = 0;
    int                          hold_seen = 0;
    int                          hold_left = 0;
    int                          quiet_cycles = 0;

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0h, want %0h", what, got, want);
        err_count++;
    endtask

    // Advances the raster position by one source pixel; returns 1 when an output pixel results.
    function automatic bit box_filter_step(input logic [3:0][7:0] pix,
                                           output mbd_pkg::t_out_item res);
        int              we;
        int              he;
        int              len;
        int              pos;
        int              w_out;
        int              h_out;
        int              idx;
        logic [3:0][7:0] px;
        logic [3:0][8:0] s;
        logic [3:0][7:0] avg;
        bit              made;
        bit              lst;
        we = (img_w == 0) ? 1 :
             ((img_w > mbd_pkg::MAX_WIDTH) ? mbd_pkg::MAX_WIDTH : int'(img_w));
        he = (img_h == 0) ? 1 :
             ((img_h > mbd_pkg::MAX_HEIGHT) ? mbd_pkg::MAX_HEIGHT : int'(img_h));
        for (int k = 0; k < 4; k++) px[k] = (k < chan_cnt) ? pix[k] : 8'h00;
        avg = '0;
        made = 1'b0;
        lst = 1'b0;
        if (we == 1 || he == 1) begin
            len = (we == 1) ? he : we;
            pos = (he == 1) ? col_pos : row_pos;
            if (len == 1) begin
                avg = px;
                lst = 1'b1;
                made = 1'b1;
            end else if (pos % 2 == 1) begin
                for (int k = 0; k < 4; k++) avg[k] = 8'((9'(held_px[k]) + 9'(px[k])) >> 1);
                lst = (pos == (len & ~1) - 1);
                made = 1'b1;
            end else begin
                held_px = px;
            end
        end else begin
            w_out = we / 2;
            h_out = he / 2;
            if (col_pos % 2 == 1) begin
                idx = col_pos / 2;
                for (int k = 0; k < 4; k++) s[k] = 9'(held_px[k]) + 9'(px[k]);
                if (row_pos < 2 * h_out) begin
                    if (row_pos % 2 == 0) begin
                        pair_sums[idx] = s;
                    end else begin
                        for (int k = 0; k < 4; k++)
                            avg[k] = 8'((11'(pair_sums[idx][k]) + 11'(s[k])) >> 2);
                        lst = (row_pos == 2 * h_out - 1) && (col_pos == 2 * w_out - 1);
                        made = 1'b1;
                    end
                end
            end else begin
                held_px = px;
            end
        end
        col_pos++;
        if (col_pos >= we) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= he) row_pos = 0;
        end
        res.chan = avg;
        res.last = lst;
        return made && chan_cnt >= 1 && chan_cnt <= 4;
    endfunction

    function automatic logic [3:0][7:0] rand_pixel();
        logic [3:0][7:0] p;
        int              sel;
        sel = $urandom_range(15);
        if (sel == 0) p = '1;
        else if (sel == 1) p = '0;
        else p = $urandom;
        return p;
    endfunction

    function automatic t_plan_row cfg_row(input logic [mbd_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [mbd_pkg::CFG_DATA_W-1:0] data);
        t_plan_row r;
        r = '{kind: PLAN_CFG, idx: idx, data: data, pix: '0, fixed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_plan_row pix_row(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d);
        t_plan_row r;
        r = '{kind: PLAN_PIX, idx: '0, data: '0, pix: {d, c, b, a}, fixed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_plan_row fix_row(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d,
                                          input logic [7:0] oa, input logic [7:0] ob,
                                          input logic [7:0] oc, input logic [7:0] od,
                                          input logic lst);
        t_plan_row r;
        r = pix_row(a, b, c, d);
        r.fixed = 1'b1;
        r.want.chan = {od, oc, ob, oa};
        r.want.last = lst;
        return r;
    endfunction

    // One pixel transfer; a fixed expectation replaces the predicted one.
    task automatic push_pixel(input logic [3:0][7:0] p, input bit fixed,
                              input mbd_pkg::t_out_item want);
        mbd_pkg::t_out_item res;
        bit                 made;
        while ($urandom_range(99) < tx_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_chan_a <= p[0];
        i_chan_b <= p[1];
        i_chan_c <= p[2];
        i_chan_d <= p[3];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        made = box_filter_step(p, res);
        if (made || fixed) expected_mip_px.push_back(fixed ? want : res);
    endtask

    // Quiesce before a register write: all results out, pipeline empty.
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_mip_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mbd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbd_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            mbd_pkg::CFG_IMAGE_WIDTH:   img_w = val;
            mbd_pkg::CFG_IMAGE_HEIGHT:  img_h = val;
            mbd_pkg::CFG_CHANNEL_COUNT: chan_cnt = val[mbd_pkg::CNT_W-1:0];
            default: ;
        endcase
        // any real register write restarts the frame
        if (idx != CFG_UNUSED) begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    // Output checking and receiver stall generation.
    always @(posedge i_clk) begin : rx_side
        logic [3:0][7:0]    got_px;
        mbd_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            got_px = {o_out_d, o_out_c, o_out_b, o_out_a};
            if (expected_mip_px.size() == 0) begin
                flag_mismatch("unexpected output pixel", int'(got_px), 0);
            end else begin
                want = expected_mip_px.pop_front();
                for (int k = 0; k < 4; k++)
                    if (got_px[k] !== want.chan[k])
                        flag_mismatch($sformatf("out channel %0d", k), got_px[k], want.chan[k]);
                if (o_frame_last !== want.last)
                    flag_mismatch("frame_last", o_frame_last, want.last);
            end
        end
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_plan_row plan [$];
        int        w;
        int        h;
        int        ch;
        int        eff;
        int        npix;
        int        sel;
        int        counted;

        // after reset: 1x1, four channels -> pass-through
        plan.push_back(fix_row(8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 1'b1));
        plan.push_back(fix_row(8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 1'b1));
        plan.push_back(cfg_row(mbd_pkg::CFG_CHANNEL_COUNT, 13'd1));
        plan.push_back(fix_row(8'h12, 8'h34, 8'h56, 8'h78, 8'h12, 8'h00, 8'h00, 8'h00, 1'b1));
        // illegal channel counts: consumed, no output
        plan.push_back(cfg_row(mbd_pkg::CFG_CHANNEL_COUNT, 13'd0));
        plan.push_back(pix_row(8'hff, 8'hff, 8'hff, 8'hff));
        plan.push_back(cfg_row(mbd_pkg::CFG_CHANNEL_COUNT, 13'd5));
        plan.push_back(pix_row(8'hff, 8'hff, 8'hff, 8'hff));
        // 2x2 at full scale
        plan.push_back(cfg_row(mbd_pkg::CFG_CHANNEL_COUNT, 13'd4));
        plan.push_back(cfg_row(mbd_pkg::CFG_IMAGE_WIDTH, 13'd2));
        plan.push_back(cfg_row(mbd_pkg::CFG_IMAGE_HEIGHT, 13'd2));
        plan.push_back(pix_row(8'hff, 8'hff, 8'hff, 8'hff));
        plan.push_back(pix_row(8'hff, 8'hff, 8'hff, 8'hff));
        plan.push_back(pix_row(8'hff, 8'hff, 8'hff, 8'hff));
        plan.push_back(fix_row(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
        // zero width reads as 1: column of 3, odd tail dropped
        plan.push_back(cfg_row(mbd_pkg::CFG_IMAGE_WIDTH, 13'd0));
        plan.push_back(cfg_row(mbd_pkg::CFG_IMAGE_HEIGHT, 13'd3));
        plan.push_back(pix_row(8'hff, 8'hff, 8'hff, 8'hff));
        plan.push_back(fix_row(8'h01, 8'h00, 8'h01, 8'h00, 8'h80, 8'h7f, 8'h80, 8'h7f, 1'b1));
        plan.push_back(pix_row(8'haa, 8'h55, 8'haa, 8'h55));
        // oversize width saturates; write to an unused index must not restart the row
        plan.push_back(cfg_row(mbd_pkg::CFG_IMAGE_WIDTH, 13'd8191));
        plan.push_back(cfg_row(mbd_pkg::CFG_IMAGE_HEIGHT, 13'd1));
        plan.push_back(pix_row(8'h00, 8'h00, 8'hff, 8'hff));
        plan.push_back(cfg_row(CFG_UNUSED, 13'h1abc));
        plan.push_back(pix_row(8'hff, 8'hff, 8'h00, 8'h00));
        plan.push_back(cfg_row(mbd_pkg::CFG_IMAGE_WIDTH, 13'd1));
        plan.push_back(cfg_row(mbd_pkg::CFG_IMAGE_HEIGHT, 13'd8191));
        plan.push_back(pix_row(8'h0f, 8'hf0, 8'h3c, 8'hc3));
        plan.push_back(pix_row(8'hf0, 8'h0f, 8'hc3, 8'h3c));
        // odd 3x3: last column and row dropped
        plan.push_back(cfg_row(mbd_pkg::CFG_IMAGE_WIDTH, 13'd3));
        plan.push_back(cfg_row(mbd_pkg::CFG_IMAGE_HEIGHT, 13'd3));
        plan.push_back(pix_row(8'h01, 8'h02, 8'h03, 8'h04));
        plan.push_back(pix_row(8'h10, 8'h20, 8'h30, 8'h40));
        plan.push_back(pix_row(8'hee, 8'hdd, 8'hcc, 8'hbb));
        plan.push_back(pix_row(8'h07, 8'h06, 8'h05, 8'h04));
        plan.push_back(pix_row(8'h80, 8'h81, 8'h82, 8'h83));
        plan.push_back(pix_row(8'h99, 8'h88, 8'h77, 8'h66));
        plan.push_back(pix_row(8'h11, 8'h22, 8'h33, 8'h44));
        plan.push_back(pix_row(8'h55, 8'h66, 8'h77, 8'h88));
        plan.push_back(pix_row(8'haa, 8'hbb, 8'hcc, 8'hdd));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == PLAN_CFG) begin
                settle();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                push_pixel(plan[i].pix, plan[i].fixed, plan[i].want);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            tx_pct = (ph == 0) ? 36 : ((ph == 1) ? 63 : 0);
            rx_pct = (ph == 0) ? 63 : ((ph == 1) ? 36 : 0);
            if (ph == 2) begin
                // 1x1 frames: every transfer yields a pixel, so a long hold fills the block
                settle();
                write_reg(mbd_pkg::CFG_IMAGE_WIDTH, 13'd1);
                write_reg(mbd_pkg::CFG_IMAGE_HEIGHT, 13'd1);
                write_reg(mbd_pkg::CFG_CHANNEL_COUNT, 13'd4);
                hold_asks++;
                repeat (BURST_ITEMS) push_pixel(rand_pixel(), 1'b0, '0);
            end
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                w = $urandom_range(1, 9);
                h = $urandom_range(1, 9);
                ch = $urandom_range(1, 4);
                sel = $urandom_range(99);
                if (sel < 8) begin
                    ch = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 7);
                end else if (sel < 14) begin
                    if ($urandom_range(1) == 1) w = 0;
                    else h = 0;
                end else if (sel < 20) begin
                    if ($urandom_range(1) == 1) begin
                        w = $urandom_range(2000, 8191);
                        h = 1;
                    end else begin
                        w = 1;
                        h = $urandom_range(2000, 8191);
                    end
                end
                eff = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
                if (sel >= 14 && sel < 20) npix = $urandom_range(20, 60);
                else if (sel >= 20 && sel < 32) npix = $urandom_range(1, eff);  // cut short
                else npix = eff * $urandom_range(1, 2);                          // frame wrap
                settle();
                write_reg(mbd_pkg::CFG_IMAGE_WIDTH, mbd_pkg::CFG_DATA_W'(w));
                write_reg(mbd_pkg::CFG_IMAGE_HEIGHT, mbd_pkg::CFG_DATA_W'(h));
                write_reg(mbd_pkg::CFG_CHANNEL_COUNT, mbd_pkg::CFG_DATA_W'(ch));
                repeat (npix) push_pixel(rand_pixel(), 1'b0, '0);
                if (ch >= 1 && ch <= 4) counted += npix;
            end
        end

        settle();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
